@@ design/text_console_writer_unit_assert.svh @@
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcw check failed");
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcw check failed");
`else
`define TCW_ASSERT_IMP(lbl, ante, cons)
`define TCW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/tcw_pkg.sv @@
// shared types and constants of the text console writer
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int ACT_W  = 3;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int CIDX_W = 2;

  localparam logic [ACT_W-1:0] ACT_PUT       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_NEWLINE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_BACKSPACE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ      = 3'd4;

  localparam logic [CIDX_W-1:0] CFG_BLANK_COLOR = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_INTERP_NL   = 2'd1;

  localparam logic [CHAR_W-1:0] BLANK_CHAR      = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR    = 8'h0a;
  localparam logic [CELL_W-1:0] CLEAR_CELL      = 16'h0020;
  localparam logic [CHAR_W-1:0] BLANK_COLOR_RST = 8'd15;

  typedef struct packed {
    logic [CHAR_W-1:0] blank_color;
    logic              interpret_newline;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] read_data;
    logic              scrolled;
  } res_t;

endpackage

@@ design/text_console_writer_unit.sv @@
// top level of the text console writer: config registers, sequencer and cell memory
// put, newline, backspace and unknown codes: decoded in S_DECODE, result strobe registered from there
// read: S_DECODE issues the memory read, S_READ captures the data; clear: an S_CLEAR sweep over every cell
// scroll: S_COPY moves rows up, S_FILL blanks the last row, then S_WRITE when a char is drawn after it
// a new item may start in the cycle of the previous result strobe
// after reset the cell memory is zeroed cell by cell in S_INIT with busy high
// synchronous active-low reset; results cannot be stalled by the receiver
`timescale 1ns / 1ps
`include "text_console_writer_unit_assert.svh"
module text_console_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [tcw_pkg::ACT_W-1:0]    in_action,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_color,
  input  logic [tcw_pkg::POS_W-1:0]    in_cell_index,
  output logic                         out_valid,
  output logic [tcw_pkg::POS_W-1:0]    out_cursor_pos,
  output logic [tcw_pkg::CELL_W-1:0]   out_read_data,
  output logic                         out_scrolled,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tcw_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::CHAR_W-1:0]   cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [POS_W-1:0] LAST_ROW_POS = POS_W'(CELLS - COLUMNS);

  cfg_t              cfg_r;
  res_t              res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blank_color       <= BLANK_COLOR_RST;
      cfg_r.interpret_newline <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      priority if (cfg_index == CFG_BLANK_COLOR) begin
        cfg_r.blank_color <= cfg_data;
      end else if (cfg_index == CFG_INTERP_NL) begin
        cfg_r.interpret_newline <= cfg_data[0];
      end else begin
        cfg_r <= cfg_r;
      end
    end
  end

  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_char_code  (in_char_code),
    .in_color      (in_color),
    .in_cell_index (in_cell_index),
    .cfg           (cfg_r),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .res           (res)
  );

  tcw_ram #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid      = res.valid;
  assign out_cursor_pos = res.cursor_pos;
  assign out_read_data  = res.read_data;
  assign out_scrolled   = res.scrolled;

  // result strobe only ever comes with the sequencer back in idle
  `TCW_ASSERT_IMP(a_strobe_when_idle, out_valid, !busy)
  // an accepted transaction always leaves the sequencer busy, with no result strobe, once accepted
  `TCW_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && !out_valid)
  // a scroll leaves the cursor at the start of the last row, or just after a drawn char
  `TCW_ASSERT_IMP(a_scroll_cursor, out_valid && out_scrolled,
                  (out_cursor_pos == LAST_ROW_POS) ||
                  (out_cursor_pos == LAST_ROW_POS + POS_W'(1)))

endmodule

@@ design/tcw_ram.sv @@
// screen cell memory, one write and one registered read port
`timescale 1ns / 1ps
module tcw_ram #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [$clog2(COLUMNS*ROWS)-1:0]    waddr,
  input  logic [tcw_pkg::CELL_W-1:0]         wdata,
  input  logic                               re,
  input  logic [$clog2(COLUMNS*ROWS)-1:0]    raddr,
  output logic [tcw_pkg::CELL_W-1:0]         rdata
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/tcw_seq.sv @@
// sequencer: cursor tracking, item decode, scroll, clear and init sweeps
`timescale 1ns / 1ps
module tcw_seq #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [tcw_pkg::ACT_W-1:0]          in_action,
  input  logic [tcw_pkg::CHAR_W-1:0]         in_char_code,
  input  logic [tcw_pkg::CHAR_W-1:0]         in_color,
  input  logic [tcw_pkg::POS_W-1:0]          in_cell_index,
  input  tcw_pkg::cfg_t                      cfg,
  output logic                               mem_we,
  output logic [$clog2(COLUMNS*ROWS)-1:0]    mem_waddr,
  output logic [tcw_pkg::CELL_W-1:0]         mem_wdata,
  output logic                               mem_re,
  output logic [$clog2(COLUMNS*ROWS)-1:0]    mem_raddr,
  input  logic [tcw_pkg::CELL_W-1:0]         mem_rdata,
  output tcw_pkg::res_t                      res
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);
  localparam logic [AW-1:0] COLS_A        = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] LAST_COL      = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_DECODE, S_COPY, S_FILL, S_WRITE, S_CLEAR, S_READ
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic              pend_r, pend_nxt;
  logic              valid_r, valid_nxt;
  logic              scr_r, scr_nxt;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic [CHAR_W-1:0] color_r, color_nxt;
  logic [POS_W-1:0]  addr_r, addr_nxt;
  logic [CELL_W-1:0] data_r, data_nxt;

  logic [AW-1:0]     lin;
  logic              is_nl;
  logic [CELL_W-1:0] blank_cell;

  assign lin        = base_r + AW'(col_r);
  assign blank_cell = {cfg.blank_color, BLANK_CHAR};
  assign is_nl      = (act_r == ACT_NEWLINE) ||
                      ((act_r == ACT_PUT) && cfg.interpret_newline &&
                       (char_r == NEWLINE_CHAR));

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    base_nxt  = base_r;
    pend_nxt  = pend_r;
    valid_nxt = 1'b0;
    scr_nxt   = scr_r;
    act_nxt   = act_r;
    char_nxt  = char_r;
    color_nxt = color_r;
    addr_nxt  = addr_r;
    data_nxt  = data_r;
    mem_we    = 1'b0;
    mem_waddr = ptr_r;
    mem_wdata = blank_cell;
    mem_re    = 1'b0;
    mem_raddr = ptr_r + COLS_A;

    unique case (state_r)
      S_INIT: begin
        // zero every cell once after reset
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          act_nxt   = in_action;
          char_nxt  = in_char_code;
          color_nxt = in_color;
          addr_nxt  = in_cell_index;
          data_nxt  = '0;
          scr_nxt   = 1'b0;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (is_nl) begin
          if (row_r == LAST_ROW) begin
            ptr_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_COPY;
          end else begin
            row_nxt   = row_r + RW'(1);
            base_nxt  = base_r + COLS_A;
            col_nxt   = '0;
            valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (act_r == ACT_PUT) begin
          if (col_r == LAST_COL) begin
            // last column is skipped: wrap first, then draw
            if (row_r == LAST_ROW) begin
              ptr_nxt   = '0;
              pend_nxt  = 1'b1;
              state_nxt = S_COPY;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = base_r + COLS_A;
              mem_wdata = {color_r, char_r};
              row_nxt   = row_r + RW'(1);
              base_nxt  = base_r + COLS_A;
              col_nxt   = CW'(1);
              valid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            mem_we    = 1'b1;
            mem_waddr = lin;
            mem_wdata = {color_r, char_r};
            col_nxt   = col_r + CW'(1);
            valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (act_r == ACT_BACKSPACE) begin
          if (lin != '0) begin
            mem_we    = 1'b1;
            mem_waddr = lin - AW'(1);
            if (col_r == '0) begin
              col_nxt  = LAST_COL;
              row_nxt  = row_r - RW'(1);
              base_nxt = base_r - COLS_A;
            end else begin
              col_nxt = col_r - CW'(1);
            end
          end
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (act_r == ACT_CLEAR) begin
          ptr_nxt   = '0;
          state_nxt = S_CLEAR;
        end else if (act_r == ACT_READ) begin
          if (32'(addr_r) < CELLS) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(addr_r);
            state_nxt = S_READ;
          end else begin
            valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_COPY: begin
        // read one row ahead, write back the cell read the cycle before
        mem_re    = (ptr_r != LAST_ROW_BASE);
        mem_raddr = ptr_r + COLS_A;
        mem_we    = (ptr_r != '0);
        mem_waddr = ptr_r - AW'(1);
        mem_wdata = mem_rdata;
        if (ptr_r == LAST_ROW_BASE) begin
          state_nxt = S_FILL;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt  = '0;
          row_nxt  = LAST_ROW;
          base_nxt = LAST_ROW_BASE;
          col_nxt  = '0;
          scr_nxt  = 1'b1;
          if (pend_r) begin
            state_nxt = S_WRITE;
          end else begin
            valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = base_r;
        mem_wdata = {color_r, char_r};
        col_nxt   = CW'(1);
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = CLEAR_CELL;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_READ: begin
        data_nxt  = mem_rdata;
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ptr_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      base_r  <= '0;
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
      scr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      base_r  <= base_nxt;
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
      scr_r   <= scr_nxt;
    end
    act_r   <= act_nxt;
    char_r  <= char_nxt;
    color_r <= color_nxt;
    addr_r  <= addr_nxt;
    data_r  <= data_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign res.valid      = valid_r;
  assign res.cursor_pos = POS_W'(lin);
  assign res.read_data  = data_r;
  assign res.scrolled   = scr_r;

endmodule
